// ----- design/shading_table_flatness_check_macros.svh -----
// Assertion macros for the shading table flatness check.
// Used by the port checker; needs a clock named clk and a reset named rst in scope.
`ifndef SHADING_TABLE_FLATNESS_CHECK_MACROS_SVH
`define SHADING_TABLE_FLATNESS_CHECK_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define STFC_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define STFC_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- design/stfc_pkg.sv -----
// Shared constants, widths and types of the shading table flatness check.
// No dependencies; used by every module of the block.
package stfc_pkg;

  // Default grid geometry.
  localparam int GRID_ROWS_DEF  = 16;
  localparam int GRID_COLS_DEF  = 16;
  localparam int EDGE_WIDTH_DEF = 5;

  // Field and datapath widths.
  localparam int SAMPLE_W = 16;
  localparam int D1_W     = 19;
  localparam int D2_W     = 21;
  localparam int SUM_W    = 23;
  localparam int LIM_W    = 22;
  localparam int ROWI_W   = 4;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // First input rows at which the first and second differences exist.
  localparam int D1_ROW_FIRST = 2;
  localparam int D2_ROW_FIRST = 4;

  // Register select, taken from the word address bit of paddr.
  localparam logic REG_FLAT_LIMIT = 1'b0;

  typedef logic signed [D2_W-1:0]  d2_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Position flags of one item as it moves into the statistics stage.
  typedef struct packed {
    logic first_col;
    logic in_left;
    logic in_right;
    logic last_col;
    logic d2_row;
    logic last_row;
  } stage_ctrl_t;

endpackage

// ----- design/stfc_diff_front.sv -----
// Grid position counters, raw and difference line stores, and the two
// vertical second differences. Depends on stfc_pkg.
module stfc_diff_front #(
  parameter int GRID_ROWS  = stfc_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS  = stfc_pkg::GRID_COLS_DEF,
  parameter int EDGE_WIDTH = stfc_pkg::EDGE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [stfc_pkg::SAMPLE_W-1:0] sample,
  output stfc_pkg::d2_t                 d2,
  output stfc_pkg::stage_ctrl_t         ctrl,
  output logic [stfc_pkg::ROWI_W-1:0]   row_index
);

  localparam int COL_W = $clog2(GRID_COLS);
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int LINE_DEPTH = 2 * GRID_COLS;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             last_col;
  logic             last_row;

  // Delay lines: tap GRID_COLS-1 is the row above, tap 2*GRID_COLS-1 two rows above.
  logic [stfc_pkg::SAMPLE_W-1:0]    raw_line  [LINE_DEPTH];
  logic signed [stfc_pkg::D1_W-1:0] diff_line [LINE_DEPTH];

  logic signed [stfc_pkg::D1_W-1:0] d1;

  assign last_col = (col == COL_W'(GRID_COLS - 1));
  assign last_row = (row == ROW_W'(GRID_ROWS - 1));

  // Raster position of the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (take) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Both line stores shift once per accepted item.
  always_ff @(posedge clk) begin
    if (take) begin
      raw_line[0]  <= sample;
      diff_line[0] <= d1;
      for (int i = 1; i < LINE_DEPTH; i++) begin
        raw_line[i]  <= raw_line[i-1];
        diff_line[i] <= diff_line[i-1];
      end
    end
  end

  // First difference of three raw rows, then the same over three difference rows.
  always_comb begin
    d1 = stfc_pkg::D1_W'(raw_line[GRID_COLS-1]) + stfc_pkg::D1_W'(raw_line[GRID_COLS-1])
       - stfc_pkg::D1_W'(raw_line[LINE_DEPTH-1]) - stfc_pkg::D1_W'(sample);
    d2 = stfc_pkg::D2_W'(diff_line[GRID_COLS-1]) + stfc_pkg::D2_W'(diff_line[GRID_COLS-1])
       - stfc_pkg::D2_W'(diff_line[LINE_DEPTH-1]) - stfc_pkg::D2_W'(d1);
  end

  // Position flags that travel with the item.
  always_comb begin
    ctrl.first_col = (col == '0);
    ctrl.in_left   = (int'(col) < EDGE_WIDTH);
    ctrl.in_right  = (int'(col) + EDGE_WIDTH >= GRID_COLS);
    ctrl.last_col  = last_col;
    ctrl.d2_row    = (row >= ROW_W'(stfc_pkg::D2_ROW_FIRST));
    ctrl.last_row  = last_row;
    row_index      = stfc_pkg::ROWI_W'(row - ROW_W'(stfc_pkg::D2_ROW_FIRST));
  end

endmodule

// ----- design/stfc_edge_stats.sv -----
// Edge window accumulators, running extremes of the frame and the limit check.
// Depends on stfc_pkg.
module stfc_edge_stats (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  stfc_pkg::stage_ctrl_t       ctrl,
  input  stfc_pkg::d2_t               d2,
  input  logic [stfc_pkg::LIM_W-1:0]  flat_limit,
  output stfc_pkg::sum_t              left_sum,
  output stfc_pkg::sum_t              right_sum,
  output stfc_pkg::sum_t              sum_max,
  output stfc_pkg::sum_t              sum_min,
  output logic                        within_limit
);

  localparam int CMP_W = stfc_pkg::SUM_W + 1;

  stfc_pkg::sum_t left_acc;
  stfc_pkg::sum_t right_acc;
  stfc_pkg::sum_t max_seen;
  stfc_pkg::sum_t min_seen;
  logic           seen_valid;

  stfc_pkg::sum_t left_base;
  stfc_pkg::sum_t right_base;
  stfc_pkg::sum_t d2_ext;
  stfc_pkg::sum_t max_left;
  stfc_pkg::sum_t min_left;

  logic signed [CMP_W-1:0] lim_pos;
  logic signed [CMP_W-1:0] lim_neg;

  // Window sums including the item now in the stage.
  always_comb begin
    d2_ext     = stfc_pkg::SUM_W'(d2);
    left_base  = ctrl.first_col ? stfc_pkg::sum_t'(0) : left_acc;
    right_base = ctrl.first_col ? stfc_pkg::sum_t'(0) : right_acc;
    left_sum   = ctrl.in_left  ? left_base + d2_ext  : left_base;
    right_sum  = ctrl.in_right ? right_base + d2_ext : right_base;
  end

  // The left sum is merged first; on a fresh frame it replaces the stored extremes.
  always_comb begin
    if (seen_valid) begin
      max_left = (left_sum > max_seen) ? left_sum : max_seen;
      min_left = (left_sum < min_seen) ? left_sum : min_seen;
    end else begin
      max_left = left_sum;
      min_left = left_sum;
    end
    sum_max = (right_sum > max_left) ? right_sum : max_left;
    sum_min = (right_sum < min_left) ? right_sum : min_left;
  end

  // Both extremes must lie within plus or minus the limit.
  always_comb begin
    lim_pos      = CMP_W'({2'b00, flat_limit});
    lim_neg      = -lim_pos;
    within_limit = (lim_neg <= CMP_W'(sum_min)) && (CMP_W'(sum_max) <= lim_pos);
  end

  // Running state; the extremes are cleared after the last row of the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_acc   <= '0;
      right_acc  <= '0;
      max_seen   <= '0;
      min_seen   <= '0;
      seen_valid <= 1'b0;
    end else if (advance && ctrl.d2_row) begin
      left_acc  <= left_sum;
      right_acc <= right_sum;
      if (ctrl.last_col) begin
        if (ctrl.last_row) begin
          max_seen   <= '0;
          min_seen   <= '0;
          seen_valid <= 1'b0;
        end else begin
          max_seen   <= sum_max;
          min_seen   <= sum_min;
          seen_valid <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/shading_table_flatness_check.sv -----
// Shading table flatness check: takes gain grid samples in raster order and
// reports edge window sums of the fourth vertical difference once per row.
//
// Input channel: sample with in_valid / in_stall; an item is accepted at a
// rising edge with in_valid high and in_stall low. One item per cycle is
// sustained while the output register is not held by the receiver.
// Output channel: one result on the last column of each row from row 4 on,
// with out_valid / out_stall. The line store taps and differences of an
// accepted sample go into the stage register; the accumulate, extreme and
// limit logic then feeds the output register.
// If the receiver stalls, the result waits in the output register and the
// block keeps taking items until a second result is due; then in_stall rises
// until the output register is free.
// Configuration: APB write of flat_limit at byte address 0, no wait states.
// Reset (rst, synchronous) clears position counters, sums, extremes, the
// limit and both pipeline valids; line store contents need no clearing.
// Depends on stfc_pkg, stfc_diff_front and stfc_edge_stats.
module shading_table_flatness_check #(
  parameter int GRID_ROWS  = stfc_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS  = stfc_pkg::GRID_COLS_DEF,
  parameter int EDGE_WIDTH = stfc_pkg::EDGE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stfc_pkg::ADDR_W-1:0]   paddr,
  input  logic [stfc_pkg::DATA_W-1:0]   pwdata,
  output logic [stfc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stfc_pkg::SAMPLE_W-1:0] sample,
  // Output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [stfc_pkg::ROWI_W-1:0]   row_index,
  output stfc_pkg::sum_t                left_sum,
  output stfc_pkg::sum_t                right_sum,
  output stfc_pkg::sum_t                sum_max,
  output stfc_pkg::sum_t                sum_min,
  output logic                          within_limit,
  output logic                          frame_done
);

  logic [stfc_pkg::LIM_W-1:0] flat_limit;

  logic                        take;
  stfc_pkg::d2_t               front_d2;
  stfc_pkg::stage_ctrl_t       front_ctrl;
  logic [stfc_pkg::ROWI_W-1:0] front_row_index;

  logic                        s1_valid;
  stfc_pkg::d2_t               s1_d2;
  stfc_pkg::stage_ctrl_t       s1_ctrl;
  logic [stfc_pkg::ROWI_W-1:0] s1_row_index;
  logic                        s1_result;
  logic                        s1_advance;

  stfc_pkg::sum_t              st_left;
  stfc_pkg::sum_t              st_right;
  stfc_pkg::sum_t              st_max;
  stfc_pkg::sum_t              st_min;
  logic                        st_within;

  // Configuration register; the word address bit selects the register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_limit <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == stfc_pkg::REG_FLAT_LIMIT)) begin
      flat_limit <= pwdata[stfc_pkg::LIM_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == stfc_pkg::REG_FLAT_LIMIT) begin
      prdata = stfc_pkg::DATA_W'(flat_limit);
    end else begin
      prdata = '0;
    end
  end

  // Handshake: the stage moves on unless its result finds the output register held.
  assign s1_result  = s1_ctrl.last_col && s1_ctrl.d2_row;
  assign s1_advance = s1_valid && !(s1_result && out_valid && out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign take       = in_valid && !in_stall;

  stfc_diff_front #(
    .GRID_ROWS  (GRID_ROWS),
    .GRID_COLS  (GRID_COLS),
    .EDGE_WIDTH (EDGE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .sample    (sample),
    .d2        (front_d2),
    .ctrl      (front_ctrl),
    .row_index (front_row_index)
  );

  // Stage register between the line stores and the statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_d2        <= front_d2;
      s1_ctrl      <= front_ctrl;
      s1_row_index <= front_row_index;
    end
  end

  stfc_edge_stats u_stats (
    .clk          (clk),
    .rst          (rst),
    .advance      (s1_advance),
    .ctrl         (s1_ctrl),
    .d2           (s1_d2),
    .flat_limit   (flat_limit),
    .left_sum     (st_left),
    .right_sum    (st_right),
    .sum_max      (st_max),
    .sum_min      (st_min),
    .within_limit (st_within)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_result) begin
      row_index    <= s1_row_index;
      left_sum     <= st_left;
      right_sum    <= st_right;
      sum_max      <= st_max;
      sum_min      <= st_min;
      within_limit <= st_within;
      frame_done   <= s1_ctrl.last_row;
    end
  end

endmodule

// ----- design/stfc_port_checker.sv -----
// Port-level checks of the shading table flatness check, bound to the top level.
// Depends on stfc_pkg and the assertion macros header.
`include "shading_table_flatness_check_macros.svh"

module stfc_port_checker #(
  parameter int GRID_ROWS = stfc_pkg::GRID_ROWS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [stfc_pkg::ROWI_W-1:0] row_index,
  input stfc_pkg::sum_t              left_sum,
  input stfc_pkg::sum_t              right_sum,
  input stfc_pkg::sum_t              sum_max,
  input stfc_pkg::sum_t              sum_min,
  input logic                        frame_done
);

  localparam logic [stfc_pkg::ROWI_W-1:0] LAST_ROW_INDEX =
    stfc_pkg::ROWI_W'(GRID_ROWS - 1 - stfc_pkg::D2_ROW_FIRST);

  // A held result stays offered.
  `STFC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // The frame verdict comes with the last difference row.
  `STFC_ASSERT_IMP(a_done_row, out_valid && frame_done, row_index == LAST_ROW_INDEX, "frame_done on wrong row")

  // Running extremes enclose both sums of the row they include.
  `STFC_ASSERT_IMP(a_max_bound, out_valid, (sum_max >= left_sum) && (sum_max >= right_sum), "maximum below a row sum")
  `STFC_ASSERT_IMP(a_min_bound, out_valid, (sum_min <= left_sum) && (sum_min <= right_sum), "minimum above a row sum")

endmodule

bind shading_table_flatness_check stfc_port_checker #(
  .GRID_ROWS (GRID_ROWS)
) u_port_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .row_index  (row_index),
  .left_sum   (left_sum),
  .right_sum  (right_sum),
  .sum_max    (sum_max),
  .sum_min    (sum_min),
  .frame_done (frame_done)
);
